>>> hdl/b64e_pkg.sv
package b64e_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgIdxChar62 = 2'd0;
  localparam logic [1:0] CfgIdxChar63 = 2'd1;

  localparam logic [7:0] Char62Reset = 8'd45;  // '-'
  localparam logic [7:0] Char63Reset = 8'd95;  // '_'

  // Up to four characters from one input beat, plus the index of the last one
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
  } b64e_beat_t;

  // 6-bit group to ASCII; values 62 and 63 come from the alphabet registers
  function automatic logic [7:0] map_group(input logic [5:0] v,
                                           input logic [7:0] c62,
                                           input logic [7:0] c63);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      map_group = 8'd65 + v8;
    end else if (v < 6'd52) begin
      map_group = 8'd97 + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      map_group = 8'd48 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      map_group = c62;
    end else begin
      map_group = c63;
    end
  endfunction

endpackage

>>> hdl/b64e_out_buf.sv
module b64e_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64e_pkg::b64e_beat_t push_beat_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          encoded_char_o,
  output logic                run_last_o
);
  import b64e_pkg::*;

  // Holding stage (a) in front of the character serializer (s)
  logic       a_valid_q;
  b64e_beat_t a_q;
  logic       s_valid_q;
  b64e_beat_t s_q;
  logic [1:0] idx_q;

  logic s_last, s_done, s_free, a_move, push_ok;

  assign s_last  = (idx_q == s_q.last_idx);
  assign s_done  = s_valid_q && out_ready_i && s_last;
  assign s_free  = !s_valid_q || s_done;
  assign a_move  = a_valid_q && s_free;
  assign ready_o = !a_valid_q || s_free;
  assign push_ok = push_i && ready_o;

  assign out_valid_o    = s_valid_q;
  assign encoded_char_o = s_q.chars[idx_q];
  assign run_last_o     = s_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      if (push_ok) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        s_valid_q <= 1'b1;
        idx_q     <= 2'd0;
      end else if (s_done) begin
        s_valid_q <= 1'b0;
      end else if (s_valid_q && out_ready_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      a_q <= push_beat_i;
    end
    if (a_move) begin
      s_q <= a_q;
    end
  end

  // serializer never walks past the last character of its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> (idx_q <= s_q.last_idx))
    else $error("serializer index past last character");

  // a beat handed over from the holding stage starts at character zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move |=> (s_valid_q && idx_q == 2'd0))
    else $error("handover did not restart serializer");

  // a beat is never pushed over a held one that is not moving on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !s_free) |-> !push_ok)
    else $error("holding stage overwritten");

endmodule

>>> hdl/base64_stream_encoder_top.sv
// Channel | Handshake                 | Payload
// --------+---------------------------+-----------------------------------
// in      | in_valid_i / in_ready_o   | data_byte_i[7:0], final_byte_i
// out     | out_valid_o / out_ready_i | encoded_char_o[7:0], run_last_o
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i[1:0], cfg_data_i[7:0]
//
// One input beat is taken per cycle while the holding stage can drain; one
// character leaves per cycle while out_ready_i is high, so the single output
// port sets a message's pace. A group is registered in the holding stage and
// then the serializer before its first character appears. Reset (async,
// active low) clears pending bytes and count and sets the alphabet to '-' and
// '_'. An output stall backs up into the holding stage, then drops in_ready_o.
module base64_stream_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] encoded_char_o,
  output logic       run_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import b64e_pkg::*;

  // Alphabet registers for values 62 and 63
  logic [7:0] char62_q, char63_q;

  // Pending bytes of an incomplete 3-byte group
  logic [1:0][7:0] held_q;
  logic [1:0]      held_cnt_q;

  logic       in_acc;
  logic       emit;
  logic [7:0] t0, t1, t2;
  logic [3:0][5:0] grp;
  b64e_beat_t beat;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;

  // Emit on a completed group or on the final byte of a message
  assign emit = (held_cnt_q == 2'd2) || final_byte_i;

  // Assemble the 24-bit group; slots past the new byte are zero-filled
  always_comb begin
    t0 = (held_cnt_q == 2'd0) ? data_byte_i : held_q[0];
    case (held_cnt_q)
      2'd0:    t1 = 8'd0;
      2'd1:    t1 = data_byte_i;
      default: t1 = held_q[1];
    endcase
    t2 = (held_cnt_q == 2'd2) ? data_byte_i : 8'd0;

    grp[0] = t0[7:2];
    grp[1] = {t0[1:0], t1[7:4]};
    grp[2] = {t1[3:0], t2[7:6]};
    grp[3] = t2[5:0];

    for (int k = 0; k < 4; k++) begin
      beat.chars[k] = map_group(grp[k], char62_q, char63_q);
    end
    // 1 byte -> 2 chars, 2 bytes -> 3 chars, 3 bytes -> 4 chars
    beat.last_idx = held_cnt_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char62_q   <= Char62Reset;
      char63_q   <= Char63Reset;
      held_q     <= '0;
      held_cnt_q <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgIdxChar62: char62_q <= cfg_data_i;
          CfgIdxChar63: char63_q <= cfg_data_i;
          default: ;  // writes beyond the register list are dropped
        endcase
      end
      if (in_acc) begin
        if (emit) begin
          held_q     <= '0;
          held_cnt_q <= 2'd0;
        end else begin
          held_q[held_cnt_q[0]] <= data_byte_i;
          held_cnt_q            <= held_cnt_q + 2'd1;
        end
      end
    end
  end

  b64e_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (in_valid_i && emit),
    .push_beat_i    (beat),
    .ready_o        (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .encoded_char_o (encoded_char_o),
    .run_last_o     (run_last_o)
  );

  // pending count never reaches a full group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("pending count overflow");

  // an emitting beat leaves the pending state empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> (held_cnt_q == 2'd0))
    else $error("pending state not cleared after emit");

  // a held byte bumps the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !emit) |=> (held_cnt_q == $past(held_cnt_q) + 2'd1))
    else $error("pending count did not advance");

endmodule
